[rtl/dod_pkg.sv]
package dod_pkg;

   localparam int NUM_CLASSES_DEF     = 80;
   localparam int COORD_FRAC_BITS_DEF = 8;

   localparam int IN_W    = 24;
   localparam int SCORE_W = 16;
   localparam int CLASS_W = 8;
   localparam int PIX_W   = 13;
   localparam int INV_W   = 24;
   localparam int IDX_W   = 8;
   localparam int DATA_W  = 24;

   // scaled coordinates stay below 2^39 in magnitude
   localparam int COORD_W = 40;
   localparam int MUL_W   = 25;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int ACC_W   = 64;
   localparam int RES_W   = 44;
   localparam int LO_W    = 24;

   localparam logic [IDX_W-1:0] CSR_NET_WIDTH   = 8'd0;
   localparam logic [IDX_W-1:0] CSR_NET_HEIGHT  = 8'd1;
   localparam logic [IDX_W-1:0] CSR_ORIG_WIDTH  = 8'd2;
   localparam logic [IDX_W-1:0] CSR_ORIG_HEIGHT = 8'd3;
   localparam logic [IDX_W-1:0] CSR_THRESHOLD   = 8'd4;
   localparam logic [IDX_W-1:0] CSR_INV_RATIO   = 8'd5;
   localparam logic [IDX_W-1:0] CSR_PAD_X       = 8'd6;
   localparam logic [IDX_W-1:0] CSR_PAD_Y       = 8'd7;

   localparam logic [PIX_W-1:0]   NET_SIZE_RST  = 13'd640;
   localparam logic [PIX_W-1:0]   ORIG_SIZE_RST = 13'd640;
   localparam logic [SCORE_W-1:0] THRESHOLD_RST = 16'd16384;
   localparam logic [INV_W-1:0]   INV_RATIO_RST = 24'd65536;
   localparam logic [PIX_W-1:0]   PAD_RST       = 13'd0;

   typedef struct packed {
      logic [PIX_W-1:0]   net_width;
      logic [PIX_W-1:0]   net_height;
      logic [PIX_W-1:0]   orig_width;
      logic [PIX_W-1:0]   orig_height;
      logic [SCORE_W-1:0] conf_threshold;
      logic [INV_W-1:0]   inv_ratio;
      logic [PIX_W-1:0]   pad_x;
      logic [PIX_W-1:0]   pad_y;
   } cfg_type;

   typedef struct packed {
      logic               fire;
      logic [SCORE_W-1:0] score;
      logic [CLASS_W-1:0] class_index;
   } close_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_SUM,
      ST_MUL,
      ST_CLAMP_POS,
      ST_CLAMP_SIZE,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      PH_LO,
      PH_HI,
      PH_ACC,
      PH_FIN
   } phase_type;

endpackage

[rtl/dod_if.sv]
interface dod_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [dod_pkg::IN_W-1:0]    center_x;
   logic signed [dod_pkg::IN_W-1:0]    center_y;
   logic signed [dod_pkg::IN_W-1:0]    box_width;
   logic signed [dod_pkg::IN_W-1:0]    box_height;
   logic        [dod_pkg::SCORE_W-1:0] class_score;
   logic                               last_class;

   modport source (output valid, center_x, center_y, box_width, box_height,
                   class_score, last_class, input ready);
   modport sink (input valid, center_x, center_y, box_width, box_height,
                 class_score, last_class, output ready);
endinterface

interface dod_rsp_if;
   logic                               valid;
   logic                               ready;
   logic        [dod_pkg::PIX_W-1:0]   left;
   logic        [dod_pkg::PIX_W-1:0]   top;
   logic        [dod_pkg::PIX_W-1:0]   width;
   logic        [dod_pkg::PIX_W-1:0]   height;
   logic        [dod_pkg::CLASS_W-1:0] class_index;
   logic        [dod_pkg::SCORE_W-1:0] confidence;

   modport source (output valid, left, top, width, height, class_index, confidence,
                   input ready);
   modport sink (input valid, left, top, width, height, class_index, confidence,
                 output ready);
endinterface

interface dod_csr_if;
   logic                              valid;
   logic                              ready;
   logic        [dod_pkg::IDX_W-1:0]  index;
   logic        [dod_pkg::DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[rtl/detector_output_decode.sv]
// Detector output decode: per-anchor class argmax and letterbox box decode.
// req: one class score per transfer, with the anchor's box fields alongside;
//   last_class closes the anchor (so does the final class position).
// rsp: at most one box per anchor, when the best score exceeds conf_threshold.
// csr: register writes, always ready; write only while the block is idle.
// Score transfers are taken one per cycle. A closing transfer that yields a
// box makes req.ready drop while the shared multiplier works through the box:
// size scaling (normalised boxes only), centre-to-corner sums, the four
// inverse-ratio products (two partial products each), clamping and the load
// of the output register. A closing transfer below threshold does not stall.
// Reset restores the register defaults, clears the argmax and drops rsp.valid.
// A stalled result is held in the output register; score transfers continue,
// and a further box waits in its final stage until the register frees.
module detector_output_decode #(
   parameter int NUM_CLASSES     = dod_pkg::NUM_CLASSES_DEF,
   parameter int COORD_FRAC_BITS = dod_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   dod_req_if.sink    req_bus,
   dod_rsp_if.source  rsp_bus,
   dod_csr_if.sink    csr_bus
);

   dod_pkg::cfg_type   cfg_ff;
   dod_pkg::close_type close;
   logic               busy;
   logic               req_accept;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = !busy;
   assign req_accept    = req_bus.valid && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.net_width      <= dod_pkg::NET_SIZE_RST;
         cfg_ff.net_height     <= dod_pkg::NET_SIZE_RST;
         cfg_ff.orig_width     <= dod_pkg::ORIG_SIZE_RST;
         cfg_ff.orig_height    <= dod_pkg::ORIG_SIZE_RST;
         cfg_ff.conf_threshold <= dod_pkg::THRESHOLD_RST;
         cfg_ff.inv_ratio      <= dod_pkg::INV_RATIO_RST;
         cfg_ff.pad_x          <= dod_pkg::PAD_RST;
         cfg_ff.pad_y          <= dod_pkg::PAD_RST;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            dod_pkg::CSR_NET_WIDTH:   cfg_ff.net_width      <= csr_bus.data[dod_pkg::PIX_W-1:0];
            dod_pkg::CSR_NET_HEIGHT:  cfg_ff.net_height     <= csr_bus.data[dod_pkg::PIX_W-1:0];
            dod_pkg::CSR_ORIG_WIDTH:  cfg_ff.orig_width     <= csr_bus.data[dod_pkg::PIX_W-1:0];
            dod_pkg::CSR_ORIG_HEIGHT: cfg_ff.orig_height    <= csr_bus.data[dod_pkg::PIX_W-1:0];
            dod_pkg::CSR_THRESHOLD:   cfg_ff.conf_threshold <= csr_bus.data[dod_pkg::SCORE_W-1:0];
            dod_pkg::CSR_INV_RATIO:   cfg_ff.inv_ratio      <= csr_bus.data[dod_pkg::INV_W-1:0];
            dod_pkg::CSR_PAD_X:       cfg_ff.pad_x          <= csr_bus.data[dod_pkg::PIX_W-1:0];
            dod_pkg::CSR_PAD_Y:       cfg_ff.pad_y          <= csr_bus.data[dod_pkg::PIX_W-1:0];
            default: ;
         endcase
      end
   end

   dod_argmax #(
      .NUM_CLASSES (NUM_CLASSES)
   ) u_argmax (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .score     (req_bus.class_score),
      .last      (req_bus.last_class),
      .threshold (cfg_ff.conf_threshold),
      .close     (close)
   );

   dod_box #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_box (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .close      (close),
      .center_x   (req_bus.center_x),
      .center_y   (req_bus.center_y),
      .box_width  (req_bus.box_width),
      .box_height (req_bus.box_height),
      .busy       (busy),
      .rsp        (rsp_bus)
   );

endmodule

[rtl/dod_mul.sv]
module dod_mul (
   input  logic                                clock,
   input  logic signed [dod_pkg::MUL_W-1:0]    a,
   input  logic signed [dod_pkg::MUL_W-1:0]    b,
   output logic signed [dod_pkg::PROD_W-1:0]   prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= a * b;
   end

endmodule

[rtl/dod_argmax.sv]
module dod_argmax #(
   parameter int NUM_CLASSES = dod_pkg::NUM_CLASSES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [dod_pkg::SCORE_W-1:0]     score,
   input  logic                            last,
   input  logic [dod_pkg::SCORE_W-1:0]     threshold,
   output dod_pkg::close_type              close
);

   logic [dod_pkg::CLASS_W-1:0] pos_ff, pos_in;
   logic [dod_pkg::SCORE_W-1:0] best_ff, best_in;
   logic [dod_pkg::CLASS_W-1:0] cls_ff, cls_in;
   logic                        take;
   logic                        closing;
   logic [dod_pkg::SCORE_W-1:0] cand_score;
   logic [dod_pkg::CLASS_W-1:0] cand_class;

   always_comb begin
      take       = (pos_ff == '0) || (score > best_ff);
      cand_score = take ? score : best_ff;
      cand_class = take ? pos_ff : cls_ff;
      closing    = last || (pos_ff >= dod_pkg::CLASS_W'(NUM_CLASSES - 1));

      pos_in  = pos_ff;
      best_in = best_ff;
      cls_in  = cls_ff;
      if (accept) begin
         if (closing) begin
            pos_in  = '0;
            best_in = '0;
            cls_in  = '0;
         end else begin
            pos_in  = pos_ff + 1'b1;
            best_in = cand_score;
            cls_in  = cand_class;
         end
      end

      close.fire        = accept && closing && (cand_score > threshold);
      close.score       = cand_score;
      close.class_index = cand_class;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         best_ff <= '0;
         cls_ff  <= '0;
      end else begin
         pos_ff  <= pos_in;
         best_ff <= best_in;
         cls_ff  <= cls_in;
      end
   end

endmodule

[rtl/dod_box.sv]
module dod_box #(
   parameter int COORD_FRAC_BITS = dod_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dod_pkg::cfg_type                    cfg,
   input  dod_pkg::close_type                  close,
   input  logic signed [dod_pkg::IN_W-1:0]     center_x,
   input  logic signed [dod_pkg::IN_W-1:0]     center_y,
   input  logic signed [dod_pkg::IN_W-1:0]     box_width,
   input  logic signed [dod_pkg::IN_W-1:0]     box_height,
   output logic                                busy,
   dod_rsp_if.source                           rsp
);

   localparam int XY_SHIFT = 1 + COORD_FRAC_BITS + 16;
   localparam int WH_SHIFT = COORD_FRAC_BITS + 16;
   localparam logic signed [dod_pkg::ACC_W-1:0] XY_BIAS =
      (dod_pkg::ACC_W'(1) << XY_SHIFT) - dod_pkg::ACC_W'(1);
   localparam logic signed [dod_pkg::ACC_W-1:0] WH_BIAS =
      (dod_pkg::ACC_W'(1) << WH_SHIFT) - dod_pkg::ACC_W'(1);
   localparam logic signed [dod_pkg::IN_W-1:0] ONE_C =
      dod_pkg::IN_W'(1) << COORD_FRAC_BITS;

   localparam int CW = dod_pkg::COORD_W;
   localparam int PW = dod_pkg::PIX_W;

   dod_pkg::state_type state_ff, state_in;
   dod_pkg::phase_type phase_ff, phase_in;
   logic [2:0]         idx_ff, idx_in;
   logic [2:0]         idx_prev;

   logic signed [CW-1:0]                coord_ff [4];
   logic signed [dod_pkg::RES_W-1:0]    res_ff   [4];
   logic signed [dod_pkg::ACC_W-1:0]    acc_ff;
   logic [dod_pkg::SCORE_W-1:0]         bs_ff;
   logic [dod_pkg::CLASS_W-1:0]         bc_ff;
   logic [PW-1:0]                       left_ff, top_ff, wd_ff, ht_ff;
   logic                                rsp_valid_ff;
   logic                                load_rsp;
   logic                                norm;

   logic signed [dod_pkg::MUL_W-1:0]    mul_a, mul_b;
   logic signed [dod_pkg::PROD_W-1:0]   prod;

   logic signed [CW-1:0]                cur, sum_a, sum_b, pad_term, sum;
   logic signed [dod_pkg::ACC_W-1:0]    bias, biased, shifted;

   function automatic logic [PW-1:0] clamp_hi(input logic signed [dod_pkg::RES_W-1:0] v,
                                               input logic [PW-1:0] hi);
      logic signed [dod_pkg::RES_W-1:0] hi_s;
      hi_s = signed'(dod_pkg::RES_W'(hi));
      priority if (v < 0) return '0;
      else if (v > hi_s) return hi;
      else return v[PW-1:0];
   endfunction

   dod_mul u_mul (
      .clock   (clock),
      .a       (mul_a),
      .b       (mul_b),
      .prod_ff (prod)
   );

   assign norm = (box_width < ONE_C) && (box_height < ONE_C) &&
                 (center_x < ONE_C) && (center_y < ONE_C);
   assign busy     = (state_ff != dod_pkg::ST_IDLE);
   assign idx_prev = idx_ff - 3'd1;

   always_comb begin
      cur      = coord_ff[idx_ff[1:0]];
      sum_a    = idx_ff[0] ? coord_ff[1] : coord_ff[0];
      sum_b    = idx_ff[0] ? coord_ff[3] : coord_ff[2];
      pad_term = signed'(CW'(idx_ff[0] ? cfg.pad_y : cfg.pad_x)) <<< (COORD_FRAC_BITS + 1);
      sum      = (sum_a <<< 1) - sum_b - pad_term;
      // truncate toward zero
      bias     = acc_ff[dod_pkg::ACC_W-1] ? (idx_ff[1] ? WH_BIAS : XY_BIAS) : '0;
      biased   = acc_ff + bias;
      shifted  = idx_ff[1] ? (biased >>> WH_SHIFT) : (biased >>> XY_SHIFT);
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      idx_in   = idx_ff;
      mul_a    = '0;
      mul_b    = '0;
      load_rsp = 1'b0;
      unique case (state_ff)
         dod_pkg::ST_IDLE: begin
            if (close.fire) begin
               idx_in   = '0;
               phase_in = dod_pkg::PH_LO;
               state_in = norm ? dod_pkg::ST_SCALE : dod_pkg::ST_SUM;
            end
         end
         dod_pkg::ST_SCALE: begin
            mul_a = cur[dod_pkg::MUL_W-1:0];
            mul_b = dod_pkg::MUL_W'(idx_ff[0] ? cfg.net_height : cfg.net_width);
            if (idx_ff == 3'd4) begin
               idx_in   = '0;
               state_in = dod_pkg::ST_SUM;
            end else begin
               idx_in = idx_ff + 3'd1;
            end
         end
         dod_pkg::ST_SUM: begin
            if (idx_ff[0]) begin
               idx_in   = '0;
               state_in = dod_pkg::ST_MUL;
            end else begin
               idx_in = 3'd1;
            end
         end
         dod_pkg::ST_MUL: begin
            mul_b = dod_pkg::MUL_W'(cfg.inv_ratio);
            if (phase_ff == dod_pkg::PH_LO) begin
               mul_a = signed'(dod_pkg::MUL_W'(cur[dod_pkg::LO_W-1:0]));
            end else begin
               mul_a = dod_pkg::MUL_W'(signed'(cur[CW-1:dod_pkg::LO_W]));
            end
            unique case (phase_ff)
               dod_pkg::PH_LO:  phase_in = dod_pkg::PH_HI;
               dod_pkg::PH_HI:  phase_in = dod_pkg::PH_ACC;
               dod_pkg::PH_ACC: phase_in = dod_pkg::PH_FIN;
               dod_pkg::PH_FIN: begin
                  phase_in = dod_pkg::PH_LO;
                  if (idx_ff == 3'd3) begin
                     state_in = dod_pkg::ST_CLAMP_POS;
                  end else begin
                     idx_in = idx_ff + 3'd1;
                  end
               end
               default: phase_in = dod_pkg::PH_LO;
            endcase
         end
         dod_pkg::ST_CLAMP_POS:  state_in = dod_pkg::ST_CLAMP_SIZE;
         dod_pkg::ST_CLAMP_SIZE: state_in = dod_pkg::ST_DONE;
         dod_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               load_rsp = 1'b1;
               state_in = dod_pkg::ST_IDLE;
            end
         end
         default: state_in = dod_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dod_pkg::ST_IDLE;
         phase_ff <= dod_pkg::PH_LO;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         dod_pkg::ST_IDLE: begin
            if (close.fire) begin
               coord_ff[0] <= CW'(center_x);
               coord_ff[1] <= CW'(center_y);
               coord_ff[2] <= CW'(box_width);
               coord_ff[3] <= CW'(box_height);
               bs_ff       <= close.score;
               bc_ff       <= close.class_index;
            end
         end
         dod_pkg::ST_SCALE: begin
            if (idx_ff != '0) begin
               coord_ff[idx_prev[1:0]] <= prod[CW-1:0];
            end
         end
         dod_pkg::ST_SUM: begin
            coord_ff[{1'b0, idx_ff[0]}] <= sum;
         end
         dod_pkg::ST_MUL: begin
            unique case (phase_ff)
               dod_pkg::PH_LO:  ;
               dod_pkg::PH_HI:  acc_ff <= dod_pkg::ACC_W'(prod);
               dod_pkg::PH_ACC: acc_ff <= acc_ff + (dod_pkg::ACC_W'(prod) <<< dod_pkg::LO_W);
               dod_pkg::PH_FIN: res_ff[idx_ff[1:0]] <= shifted[dod_pkg::RES_W-1:0];
               default: ;
            endcase
         end
         dod_pkg::ST_CLAMP_POS: begin
            left_ff <= clamp_hi(res_ff[0], cfg.orig_width);
            top_ff  <= clamp_hi(res_ff[1], cfg.orig_height);
         end
         dod_pkg::ST_CLAMP_SIZE: begin
            wd_ff <= clamp_hi(res_ff[2], cfg.orig_width - left_ff);
            ht_ff <= clamp_hi(res_ff[3], cfg.orig_height - top_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp.left        <= left_ff;
         rsp.top         <= top_ff;
         rsp.width       <= wd_ff;
         rsp.height      <= ht_ff;
         rsp.class_index <= bc_ff;
         rsp.confidence  <= bs_ff;
      end
   end

   assign rsp.valid = rsp_valid_ff;

endmodule

[rtl/dod_checker.sv]
module dod_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [dod_pkg::PIX_W-1:0]     rsp_left,
   input logic [dod_pkg::PIX_W-1:0]     rsp_top,
   input logic [dod_pkg::PIX_W-1:0]     rsp_width,
   input logic [dod_pkg::PIX_W-1:0]     rsp_height,
   input logic [dod_pkg::CLASS_W-1:0]   rsp_class_index,
   input logic [dod_pkg::SCORE_W-1:0]   rsp_confidence
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_left) && $stable(rsp_top) &&
         $stable(rsp_width) && $stable(rsp_height) &&
         $stable(rsp_class_index) && $stable(rsp_confidence))
      else $error("rsp payload changed while stalled");

   a_box_fits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_left} + {1'b0, rsp_width} <= 14'd8191) &&
                    ({1'b0, rsp_top} + {1'b0, rsp_height} <= 14'd8191))
      else $error("box exceeds image after clamp");

   a_no_instant_box: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("box appeared one cycle after a score transfer");

endmodule

bind detector_output_decode dod_checker u_dod_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_left        (rsp_bus.left),
   .rsp_top         (rsp_bus.top),
   .rsp_width       (rsp_bus.width),
   .rsp_height      (rsp_bus.height),
   .rsp_class_index (rsp_bus.class_index),
   .rsp_confidence  (rsp_bus.confidence)
);

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;

   localparam int NCLS        = dod_pkg::NUM_CLASSES_DEF;
   localparam int FRAC        = dod_pkg::COORD_FRAC_BITS_DEF;
   localparam int LIMIT       = 400000;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE      = 64;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 220;
   localparam int DIR_ROWS    = 22;

   typedef enum logic [1:0] {
      EXP_MODEL,
      EXP_NONE,
      EXP_BOX
   } exp_kind_type;

   typedef struct packed {
      logic [dod_pkg::IN_W-1:0]    cx;
      logic [dod_pkg::IN_W-1:0]    cy;
      logic [dod_pkg::IN_W-1:0]    bw;
      logic [dod_pkg::IN_W-1:0]    bh;
      logic [dod_pkg::SCORE_W-1:0] score;
      logic                        last;
   } score_item_type;

   typedef struct packed {
      logic [dod_pkg::PIX_W-1:0]   left;
      logic [dod_pkg::PIX_W-1:0]   top;
      logic [dod_pkg::PIX_W-1:0]   width;
      logic [dod_pkg::PIX_W-1:0]   height;
      logic [dod_pkg::CLASS_W-1:0] class_index;
      logic [dod_pkg::SCORE_W-1:0] confidence;
   } box_type;

   typedef struct packed {
      score_item_type item;
      exp_kind_type   kind;
      box_type        box;
   } dir_row_type;

   localparam box_type NOBOX = '0;

   localparam dir_row_type DIRECTED_ROWS [DIR_ROWS] = '{
      '{'{24'h0, 24'h0, 24'h0, 24'h0, 16'hFFFF, 1'b1}, EXP_BOX,
        '{13'd0, 13'd0, 13'd0, 13'd0, 8'd0, 16'hFFFF}},
      '{'{24'h0, 24'h0, 24'h0, 24'h0, 16'h4000, 1'b1}, EXP_NONE, NOBOX},
      '{'{24'h0, 24'h0, 24'h0, 24'h0, 16'h4001, 1'b1}, EXP_BOX,
        '{13'd0, 13'd0, 13'd0, 13'd0, 8'd0, 16'h4001}},
      '{'{24'h0, 24'h0, 24'h0, 24'h0, 16'h0000, 1'b1}, EXP_NONE, NOBOX},
      // tie keeps the earliest class
      '{'{24'h0, 24'h0, 24'h0, 24'h0, 16'h5000, 1'b0}, EXP_NONE, NOBOX},
      '{'{24'h0, 24'h0, 24'h0, 24'h0, 16'h5000, 1'b1}, EXP_BOX,
        '{13'd0, 13'd0, 13'd0, 13'd0, 8'd0, 16'h5000}},
      '{'{24'h0, 24'h0, 24'h0, 24'h0, 16'h0064, 1'b0}, EXP_NONE, NOBOX},
      '{'{24'h0, 24'h0, 24'h0, 24'h0, 16'h9000, 1'b0}, EXP_NONE, NOBOX},
      '{'{24'h0, 24'h0, 24'h0, 24'h0, 16'h8000, 1'b1}, EXP_BOX,
        '{13'd0, 13'd0, 13'd0, 13'd0, 8'd1, 16'h9000}},
      '{'{24'h0, 24'h0, 24'h0, 24'h0, 16'hFFFF, 1'b0}, EXP_NONE, NOBOX},
      '{'{24'h0, 24'h0, 24'h0, 24'h0, 16'h0000, 1'b1}, EXP_BOX,
        '{13'd0, 13'd0, 13'd0, 13'd0, 8'd0, 16'hFFFF}},
      '{'{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 1'b1}, EXP_BOX,
        '{13'd640, 13'd640, 13'd0, 13'd0, 8'd0, 16'hFFFF}},
      '{'{24'h800000, 24'h800000, 24'h800000, 24'h800000, 16'hFFFF, 1'b1}, EXP_BOX,
        '{13'd0, 13'd0, 13'd0, 13'd0, 8'd0, 16'hFFFF}},
      '{'{24'h014000, 24'h014000, 24'h006400, 24'h006400, 16'hC000, 1'b1},
        EXP_MODEL, NOBOX},
      '{'{24'h000080, 24'h000080, 24'h000040, 24'h000040, 16'hC000, 1'b1},
        EXP_MODEL, NOBOX},
      '{'{24'h014000, 24'h014000, 24'hFF9C00, 24'h006400, 16'hC000, 1'b1},
        EXP_MODEL, NOBOX},
      '{'{24'h025800, 24'h025800, 24'h00C800, 24'h00C800, 16'hC000, 1'b1},
        EXP_MODEL, NOBOX},
      '{'{24'h000100, 24'h000040, 24'h000040, 24'h000040, 16'hC000, 1'b1},
        EXP_MODEL, NOBOX},
      // box fields of a non-closing transfer are ignored
      '{'{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h7000, 1'b0},
        EXP_NONE, NOBOX},
      '{'{24'h0, 24'h0, 24'h0, 24'h0, 16'h0001, 1'b1}, EXP_BOX,
        '{13'd0, 13'd0, 13'd0, 13'd0, 8'd0, 16'h7000}},
      '{'{24'h5A5A5A, 24'hA5A5A5, 24'h123456, 24'hEDCBA9, 16'hAAAA, 1'b1},
        EXP_MODEL, NOBOX},
      '{'{24'hA5A5A5, 24'h5A5A5A, 24'hEDCBA9, 24'h123456, 16'h5555, 1'b1},
        EXP_MODEL, NOBOX}
   };

   logic clock;
   logic reset;

   dod_req_if req_if ();
   dod_rsp_if rsp_if ();
   dod_csr_if csr_if ();

   detector_output_decode u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   dod_pkg::cfg_type            decode_cfg;
   logic [dod_pkg::SCORE_W-1:0] arg_score;
   logic [dod_pkg::CLASS_W-1:0] arg_class;
   logic [7:0]                  class_pos;

   box_type pending_boxes [$];
   box_type got_box;
   box_type want_box;

   int  send_idle;
   int  recv_idle;
   bit  hold_start;
   bit  rsp_hold;
   int  cycles;
   int  items_sent;
   int  anchors_closed;
   int  boxes_checked;
   int  mismatches;
   int  leftover;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void expect_box(box_type b);
      pending_boxes = {pending_boxes, b};
   endfunction

   function automatic longint trunc_shift(longint v, int s);
      longint m;
      m = (v < 0) ? -v : v;
      m = m >> s;
      return (v < 0) ? -m : m;
   endfunction

   function automatic longint clamp_to(longint v, longint hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void reset_decoder();
      decode_cfg.net_width      = dod_pkg::NET_SIZE_RST;
      decode_cfg.net_height     = dod_pkg::NET_SIZE_RST;
      decode_cfg.orig_width     = dod_pkg::ORIG_SIZE_RST;
      decode_cfg.orig_height    = dod_pkg::ORIG_SIZE_RST;
      decode_cfg.conf_threshold = dod_pkg::THRESHOLD_RST;
      decode_cfg.inv_ratio      = dod_pkg::INV_RATIO_RST;
      decode_cfg.pad_x          = dod_pkg::PAD_RST;
      decode_cfg.pad_y          = dod_pkg::PAD_RST;
      arg_score = '0;
      arg_class = '0;
      class_pos = '0;
   endfunction

   // argmax step; on a box-producing close, fills the decoded box
   function automatic bit decode_step(score_item_type it, output box_type box);
      longint one, cx, cy, w, h, inv, xo, yo, wo, ho, l, t, wd, ht;
      logic [dod_pkg::SCORE_W-1:0] bs;
      logic [dod_pkg::CLASS_W-1:0] bc;
      one = longint'(1) << FRAC;
      box = '0;
      if (class_pos == 0 || it.score > arg_score) begin
         arg_score = it.score;
         arg_class = class_pos;
      end
      if (!it.last && class_pos < NCLS - 1) begin
         class_pos++;
         return 1'b0;
      end
      bs = arg_score;
      bc = arg_class;
      arg_score = '0;
      arg_class = '0;
      class_pos = '0;
      anchors_closed++;
      if (bs <= decode_cfg.conf_threshold) return 1'b0;

      cx = longint'($signed(it.cx));
      cy = longint'($signed(it.cy));
      w  = longint'($signed(it.bw));
      h  = longint'($signed(it.bh));
      if (w < one && h < one && cx < one && cy < one) begin
         cx = cx * longint'(decode_cfg.net_width);
         w  = w * longint'(decode_cfg.net_width);
         cy = cy * longint'(decode_cfg.net_height);
         h  = h * longint'(decode_cfg.net_height);
      end
      inv = longint'(decode_cfg.inv_ratio);
      xo = trunc_shift((2 * cx - w - 2 * longint'(decode_cfg.pad_x) * one) * inv,
                       1 + FRAC + 16);
      yo = trunc_shift((2 * cy - h - 2 * longint'(decode_cfg.pad_y) * one) * inv,
                       1 + FRAC + 16);
      wo = trunc_shift(w * inv, FRAC + 16);
      ho = trunc_shift(h * inv, FRAC + 16);

      l  = clamp_to(xo, longint'(decode_cfg.orig_width));
      t  = clamp_to(yo, longint'(decode_cfg.orig_height));
      wd = clamp_to(wo, longint'(decode_cfg.orig_width) - l);
      ht = clamp_to(ho, longint'(decode_cfg.orig_height) - t);

      box.left        = l[dod_pkg::PIX_W-1:0];
      box.top         = t[dod_pkg::PIX_W-1:0];
      box.width       = wd[dod_pkg::PIX_W-1:0];
      box.height      = ht[dod_pkg::PIX_W-1:0];
      box.class_index = bc;
      box.confidence  = bs;
      return 1'b1;
   endfunction

   function automatic dod_pkg::cfg_type pick_config(int p);
      dod_pkg::cfg_type c;
      case (p)
         0: c = '{13'd640, 13'd640, 13'd640, 13'd640, 16'd16384, 24'd65536, 13'd0, 13'd0};
         1: c = '{13'd640, 13'd384, 13'd1920, 13'd1080, 16'd1000, 24'd196608, 13'd0, 13'd12};
         2: c = '{13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 16'hFFFF, 24'hFFFFFF,
                  13'h1FFF, 13'h1FFF};
         3: c = '{13'd1, 13'd1, 13'd1, 13'd1, 16'd0, 24'd1, 13'd0, 13'd0};
         4: c = '{13'd0, 13'd0, 13'd0, 13'd0, 16'd0, 24'd0, 13'd0, 13'd0};
         6: c = '{13'd416, 13'd416, 13'h1FFF, 13'h1FFF, 16'h0100, 24'hFFFFFF,
                  13'h1FFF, 13'd0};
         default: begin
            c.net_width      = dod_pkg::PIX_W'($urandom_range(1, 8191));
            c.net_height     = dod_pkg::PIX_W'($urandom_range(1, 8191));
            c.orig_width     = dod_pkg::PIX_W'($urandom_range(1, 8191));
            c.orig_height    = dod_pkg::PIX_W'($urandom_range(1, 8191));
            c.conf_threshold = dod_pkg::SCORE_W'($urandom_range(0, 40000));
            c.inv_ratio      = dod_pkg::INV_W'($urandom_range(1, 24'hFFFFFF));
            c.pad_x          = dod_pkg::PIX_W'($urandom_range(0, 8191));
            c.pad_y          = dod_pkg::PIX_W'($urandom_range(0, 8191));
         end
      endcase
      return c;
   endfunction

   function automatic logic [dod_pkg::IN_W-1:0] pick_coord(int style, bit is_size);
      int s;
      s = (style == 3) ? $urandom_range(2) : style;
      case (s)
         0: return dod_pkg::IN_W'($urandom_range(0, 511)) - dod_pkg::IN_W'(256);
         1: begin
            if (is_size) begin
               return dod_pkg::IN_W'($urandom_range(0, 750 * 256)) -
                      dod_pkg::IN_W'(50 * 256);
            end
            return dod_pkg::IN_W'($urandom_range(0, 1000 * 256));
         end
         default: return dod_pkg::IN_W'($urandom);
      endcase
   endfunction

   task automatic csr_put(logic [dod_pkg::IDX_W-1:0] idx, logic [dod_pkg::DATA_W-1:0] val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         dod_pkg::CSR_NET_WIDTH:   decode_cfg.net_width      = val[dod_pkg::PIX_W-1:0];
         dod_pkg::CSR_NET_HEIGHT:  decode_cfg.net_height     = val[dod_pkg::PIX_W-1:0];
         dod_pkg::CSR_ORIG_WIDTH:  decode_cfg.orig_width     = val[dod_pkg::PIX_W-1:0];
         dod_pkg::CSR_ORIG_HEIGHT: decode_cfg.orig_height    = val[dod_pkg::PIX_W-1:0];
         dod_pkg::CSR_THRESHOLD:   decode_cfg.conf_threshold = val[dod_pkg::SCORE_W-1:0];
         dod_pkg::CSR_INV_RATIO:   decode_cfg.inv_ratio      = val[dod_pkg::INV_W-1:0];
         dod_pkg::CSR_PAD_X:       decode_cfg.pad_x          = val[dod_pkg::PIX_W-1:0];
         dod_pkg::CSR_PAD_Y:       decode_cfg.pad_y          = val[dod_pkg::PIX_W-1:0];
         default: ;
      endcase
   endtask

   task automatic write_config(dod_pkg::cfg_type c);
      csr_put(dod_pkg::CSR_NET_WIDTH,   dod_pkg::DATA_W'(c.net_width));
      csr_put(dod_pkg::CSR_NET_HEIGHT,  dod_pkg::DATA_W'(c.net_height));
      csr_put(dod_pkg::CSR_ORIG_WIDTH,  dod_pkg::DATA_W'(c.orig_width));
      csr_put(dod_pkg::CSR_ORIG_HEIGHT, dod_pkg::DATA_W'(c.orig_height));
      csr_put(dod_pkg::CSR_THRESHOLD,   dod_pkg::DATA_W'(c.conf_threshold));
      csr_put(dod_pkg::CSR_INV_RATIO,   dod_pkg::DATA_W'(c.inv_ratio));
      csr_put(dod_pkg::CSR_PAD_X,       dod_pkg::DATA_W'(c.pad_x));
      csr_put(dod_pkg::CSR_PAD_Y,       dod_pkg::DATA_W'(c.pad_y));
      csr_if.valid <= 1'b0;
   endtask

   task automatic send_score(score_item_type it, exp_kind_type kind, box_type typed);
      box_type pbox;
      bit      fired;
      while ($urandom_range(99) < send_idle) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.center_x    <= it.cx;
      req_if.center_y    <= it.cy;
      req_if.box_width   <= it.bw;
      req_if.box_height  <= it.bh;
      req_if.class_score <= it.score;
      req_if.last_class  <= it.last;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
      fired = decode_step(it, pbox);
      case (kind)
         EXP_MODEL: if (fired) expect_box(pbox);
         EXP_BOX:   expect_box(typed);
         default: ;
      endcase
   endtask

   task automatic run_phase(int n);
      int                          sent, len, style, r;
      bit                          overrun, noisy;
      logic [dod_pkg::SCORE_W-1:0] prev;
      score_item_type              it;
      sent = 0;
      prev = '0;
      it   = '0;
      while (sent < n) begin
         r       = $urandom_range(99);
         overrun = (r < 8);
         len     = (r < 12) ? NCLS : $urandom_range(1, 6);
         noisy   = ($urandom_range(99) < 8);
         style   = $urandom_range(3);
         for (int k = 0; k < len; k++) begin
            if (k == 0 || noisy) begin
               it.cx = pick_coord(style, 1'b0);
               it.cy = pick_coord(style, 1'b0);
               it.bw = pick_coord(style, 1'b1);
               it.bh = pick_coord(style, 1'b1);
            end
            r = $urandom_range(99);
            if (r < 15) it.score = prev;
            else if (r < 25) it.score = '0;
            else if (r < 30) it.score = '1;
            else it.score = dod_pkg::SCORE_W'($urandom);
            prev    = it.score;
            it.last = (k == len - 1) && !overrun;
            if (noisy && $urandom_range(9) == 0) it.last = 1'b1;
            send_score(it, EXP_MODEL, NOBOX);
         end
         sent += len;
      end
      // leave no anchor open across a register change
      if (class_pos != 0) begin
         it.last = 1'b1;
         send_score(it, EXP_MODEL, NOBOX);
      end
   endtask

   task automatic settle_idle();
      while (pending_boxes.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold) rsp_if.ready <= 1'b0;
         else rsp_if.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   initial begin
      rsp_hold = 1'b0;
      wait (hold_start);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got_box = '{rsp_if.left, rsp_if.top, rsp_if.width, rsp_if.height,
                     rsp_if.class_index, rsp_if.confidence};
         if (pending_boxes.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected box: l=%0d t=%0d w=%0d h=%0d c=%0d s=%0h",
                        got_box.left, got_box.top, got_box.width, got_box.height,
                        got_box.class_index, got_box.confidence);
            mismatches++;
         end else begin
            want_box = pending_boxes.pop_front();
            boxes_checked++;
            if (got_box.left !== want_box.left || got_box.top !== want_box.top ||
                got_box.width !== want_box.width || got_box.height !== want_box.height ||
                got_box.class_index !== want_box.class_index ||
                got_box.confidence !== want_box.confidence) begin
               if (mismatches < 10) begin
                  $display("box mismatch: got l=%0d t=%0d w=%0d h=%0d c=%0d s=%0h",
                           got_box.left, got_box.top, got_box.width, got_box.height,
                           got_box.class_index, got_box.confidence);
                  $display("              exp l=%0d t=%0d w=%0d h=%0d c=%0d s=%0h",
                           want_box.left, want_box.top, want_box.width, want_box.height,
                           want_box.class_index, want_box.confidence);
               end
               mismatches++;
            end
         end
      end
   end

   initial begin
      cycles = 0;
      while (cycles <= LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles", LIMIT);
      $display("detector_output_decode test failed");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.center_x    = '0;
      req_if.center_y    = '0;
      req_if.box_width   = '0;
      req_if.box_height  = '0;
      req_if.class_score = '0;
      req_if.last_class  = 1'b0;
      csr_if.valid       = 1'b0;
      csr_if.index       = '0;
      csr_if.data        = '0;
      hold_start         = 1'b0;
      send_idle          = 30;
      recv_idle          = 49;
      items_sent         = 0;
      anchors_closed     = 0;
      boxes_checked      = 0;
      mismatches         = 0;
      leftover           = 0;
      reset_decoder();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_ROWS; i++)
         send_score(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].box);
      req_if.valid <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         settle_idle();
         if (p < 3) begin
            send_idle = 30;
            recv_idle = 49;
         end else if (p < 6) begin
            send_idle = 49;
            recv_idle = 30;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         write_config(pick_config(p));
         if (p == 0) hold_start = 1'b1;
         run_phase(PHASE_ITEMS);
         req_if.valid <= 1'b0;
      end

      settle_idle();
      leftover = pending_boxes.size();
      if (leftover != 0) $display("%0d expected boxes never arrived", leftover);
      $display("%0d score transfers over %0d register settings, %0d anchors closed, %0d boxes",
               items_sent, PHASES + 1, anchors_closed, boxes_checked);
      $display("incl. extremes, ties, class-count overruns, early marks, %0d-cycle output stall",
               HOLD_CYCLES);
      if (mismatches == 0 && leftover == 0) begin
         $display("detector_output_decode test passed");
      end else begin
         $display("detector_output_decode test failed");
      end
      $finish;
   end

endmodule
